// ----- hdl/sca_pkg.sv -----
// Shared types and constants for the size class window allocator.
`default_nettype none
package sca_pkg;

  localparam int IW     = 11;   // global slot index incl. pool end
  localparam int RB     = 5;    // row number of the slot bitmap
  localparam int ROW_W  = 32;   // slots per bitmap row
  localparam int MUL_A  = 9;
  localparam int MUL_B  = 40;
  localparam int MUL_P  = MUL_A + MUL_B;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NOFIT  = 2'd1;
  localparam logic [1:0] STAT_NOPOOL = 2'd2;

  localparam logic [2:0] REG_POOL0       = 3'd0;
  localparam logic [2:0] REG_PRIMARY     = 3'd4;
  localparam logic [2:0] REG_SECONDARY   = 3'd5;
  localparam logic [2:0] REG_CTRL_OFS    = 3'd6;
  localparam logic [2:0] REG_CTRL_STRIDE = 3'd7;
  localparam int         NUM_POOL_REGS   = 4;

  typedef struct packed {
    logic        second;
    logic [7:0]  first;
    logic [8:0]  count;
    logic [39:0] size;
  } pool_t;

  typedef struct packed {
    logic valid;
    logic to_reg;
    logic last;
  } mul_tag_t;

endpackage
`default_nettype wire

// ----- hdl/sca_scan.sv -----
// Bitmap row search: lowest free slot of one row inside a pool's index range.
`default_nettype none
module sca_scan (
  input  wire logic [sca_pkg::ROW_W-1:0] row_bits,
  input  wire logic [sca_pkg::IW-1:0]    row_base,
  input  wire logic [sca_pkg::IW-1:0]    lo,
  input  wire logic [sca_pkg::IW-1:0]    hi,
  output logic                           found,
  output logic [4:0]                     pick
);

  logic [sca_pkg::ROW_W-1:0] cand;

  always_comb begin
    for (int k = 0; k < sca_pkg::ROW_W; k++) begin
      cand[k] = !row_bits[k]
                && ((row_base + sca_pkg::IW'(k)) >= lo)
                && ((row_base + sca_pkg::IW'(k)) < hi);
    end
  end

  always_comb begin
    found = |cand;
    pick  = '0;
    for (int k = sca_pkg::ROW_W - 1; k >= 0; k--) begin
      if (cand[k]) begin
        pick = 5'(k);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sca_mul.sv -----
// Shared registered multiplier for the address sums.
`default_nettype none
module sca_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sca_pkg::mul_tag_t            tag_in,
  input  wire logic [sca_pkg::MUL_A-1:0]    a,
  input  wire logic [sca_pkg::MUL_B-1:0]    b,
  output sca_pkg::mul_tag_t                 tag_out,
  output logic [sca_pkg::MUL_P-1:0]         prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    prod <= {{sca_pkg::MUL_B{1'b0}}, a} * {{sca_pkg::MUL_A{1'b0}}, b};
  end

endmodule
`default_nettype wire

// ----- hdl/size_class_window_allocator.sv -----
// Top level: window allocator sequencer, pool registers and slot bitmap.
//
//  channel   ports                                             timing
//  request   start, busy, mode, request_size, window_index    taken when start & !busy
//  result    done, status, granted_index, window_size,         one cycle per strobe
//            window_address, register_address
//  config    wr_en, wr_index, wr_data                          written when wr_en
//
// Free, bookkeeping allocate and unused mode: result in the cycle after the request.
// Allocate: one step per pool that is too small or empty, one per bitmap row searched
// (32 slots a row), then the registered result.
// Query: one product per lower pool, then the slot and register products; a second-region
// pool gives only the last two. The shared multiplier takes one product a cycle.
// Synchronous reset clears the bitmap and the counter. Results are never stalled.
`default_nettype none
module size_class_window_allocator #(
  parameter int NUM_POOLS   = 4,
  parameter int MAX_WINDOWS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         mode,
  input  wire logic [40:0]        request_size,
  input  wire logic [7:0]         window_index,
  output logic                    done,
  output logic [1:0]              status,
  output logic signed [32:0]      granted_index,
  output logic [40:0]             window_size,
  output logic [63:0]             window_address,
  output logic [63:0]             register_address,
  input  wire logic               wr_en,
  input  wire logic [2:0]         wr_index,
  input  wire logic [63:0]        wr_data
);

  localparam int IW   = sca_pkg::IW;
  localparam int RB   = sca_pkg::RB;
  localparam int PW   = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int KW   = PW + 1;
  localparam int ROWS = (MAX_WINDOWS + sca_pkg::ROW_W - 1) / sca_pkg::ROW_W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [IW-1:0] MAXW = IW'(MAX_WINDOWS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ALLOC  = 4'b0010,
    S_QISSUE = 4'b0100,
    S_QWAIT  = 4'b1000
  } state_t;

  sca_pkg::pool_t pools [NUM_POOLS];
  logic [63:0] primary;
  logic [63:0] secondary;
  logic [31:0] ctrl_ofs;
  logic [15:0] ctrl_stride;

  logic [sca_pkg::ROW_W-1:0] slot_rows [ROWS];
  logic [31:0]  book;
  state_t       state;

  logic [PW-1:0] p_cur;
  logic [RB-1:0] r;
  logic          fresh;
  logic [40:0]   req;
  logic [7:0]    widx_q;
  logic [PW-1:0] p_q;
  logic [7:0]    slot_q;
  logic [39:0]   size_q;
  logic [KW-1:0] k;
  logic [63:0]   addr_acc;
  logic [63:0]   reg_acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        pools[i] <= '0;
      end
      primary     <= '0;
      secondary   <= '0;
      ctrl_ofs    <= '0;
      ctrl_stride <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        if (i < sca_pkg::NUM_POOL_REGS && wr_index == sca_pkg::REG_POOL0 + 3'(i)) begin
          pools[i] <= wr_data[57:0];
        end
      end
      case (wr_index)
        sca_pkg::REG_PRIMARY:     primary     <= wr_data;
        sca_pkg::REG_SECONDARY:   secondary   <= wr_data;
        sca_pkg::REG_CTRL_OFS:    ctrl_ofs    <= wr_data[31:0];
        sca_pkg::REG_CTRL_STRIDE: ctrl_stride <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // pool lookup of the requested index
  logic          lk_hit;
  logic [PW-1:0] lk_p;
  logic          any_count;

  always_comb begin
    lk_hit    = 1'b0;
    lk_p      = '0;
    any_count = 1'b0;
    for (int i = NUM_POOLS - 1; i >= 0; i--) begin
      if ({2'b0, window_index} >= {2'b0, pools[i].first}
          && {2'b0, window_index} < {2'b0, pools[i].first} + {1'b0, pools[i].count}) begin
        lk_hit = 1'b1;
        lk_p   = PW'(i);
      end
      if (pools[i].count != '0) begin
        any_count = 1'b1;
      end
    end
    if ({3'b0, window_index} >= MAXW) begin
      lk_hit = 1'b0;
    end
  end

  // one pool read port shared by all phases
  logic [PW-1:0]  sel_idx;
  sca_pkg::pool_t psel;

  always_comb begin
    case (state)
      S_ALLOC:  sel_idx = p_cur;
      S_QISSUE: sel_idx = k[PW-1:0];
      default:  sel_idx = lk_p;
    endcase
  end

  assign psel = pools[sel_idx];

  // allocate row search
  logic [IW-1:0] lo;
  logic [IW-1:0] end_idx;
  logic [IW-1:0] hi;
  logic          fits;
  logic [RB-1:0] eff_r;
  logic [IW-1:0] row_base;
  logic          row_last;
  logic          found;
  logic [4:0]    pick;
  logic [IW-1:0] grant_g;
  logic          last_pool;
  logic          adv;
  logic [sca_pkg::ROW_W-1:0] row_bits;

  assign lo       = {3'b0, psel.first};
  assign end_idx  = {3'b0, psel.first} + {2'b0, psel.count};
  assign hi       = (end_idx > MAXW) ? MAXW : end_idx;
  assign fits     = (req <= {1'b0, psel.size}) && (lo < hi);
  assign eff_r    = fresh ? {2'b0, psel.first[7:5]} : r;
  assign row_base = {1'b0, eff_r, 5'b0};
  assign row_last = {(6'({1'b0, eff_r}) + 6'd1), 5'b0} >= hi;
  assign row_bits = slot_rows[eff_r[RW-1:0]];
  assign grant_g  = row_base + {{(IW-5){1'b0}}, pick};
  assign last_pool = (p_cur == PW'(NUM_POOLS - 1));
  assign adv      = !fits || (!found && row_last);

  sca_scan u_scan (
    .row_bits (row_bits),
    .row_base (row_base),
    .lo       (lo),
    .hi       (hi),
    .found    (found),
    .pick     (pick)
  );

  // query products
  sca_pkg::mul_tag_t               tag_in;
  sca_pkg::mul_tag_t               tag_out;
  logic [sca_pkg::MUL_A-1:0]       mul_a;
  logic [sca_pkg::MUL_B-1:0]       mul_b;
  logic [sca_pkg::MUL_P-1:0]       prod;
  logic [63:0]                     prod64;

  always_comb begin
    tag_in = '0;
    mul_a  = '0;
    mul_b  = '0;
    if (state == S_QISSUE) begin
      tag_in.valid = 1'b1;
      if (k < {1'b0, p_q}) begin
        mul_a = psel.second ? '0 : psel.count;
        mul_b = psel.size;
      end else if (k == {1'b0, p_q}) begin
        mul_a = {1'b0, slot_q};
        mul_b = size_q;
      end else begin
        mul_a         = {1'b0, widx_q};
        mul_b         = {24'b0, ctrl_stride};
        tag_in.to_reg = 1'b1;
        tag_in.last   = 1'b1;
      end
    end
  end

  sca_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag_in),
    .a       (mul_a),
    .b       (mul_b),
    .tag_out (tag_out),
    .prod    (prod)
  );

  assign prod64 = {{(64 - sca_pkg::MUL_P){1'b0}}, prod};

  logic [IW-1:0] widx_ext;
  assign widx_ext = {3'b0, window_index};

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      book  <= '0;
      for (int i = 0; i < ROWS; i++) begin
        slot_rows[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            status           <= sca_pkg::STAT_OK;
            granted_index    <= '0;
            window_size      <= '0;
            window_address   <= '0;
            register_address <= '0;
            case (mode)
              sca_pkg::MODE_ALLOC: begin
                if (!any_count) begin
                  granted_index <= {1'b0, book};
                  book          <= book + 32'd1;
                  done          <= 1'b1;
                end else begin
                  req   <= request_size;
                  p_cur <= '0;
                  fresh <= 1'b1;
                  state <= S_ALLOC;
                end
              end
              sca_pkg::MODE_FREE: begin
                if (lk_hit) begin
                  slot_rows[widx_ext[5 +: RW]][widx_ext[4:0]] <= 1'b0;
                end else begin
                  status <= sca_pkg::STAT_NOPOOL;
                end
                done <= 1'b1;
              end
              sca_pkg::MODE_QUERY: begin
                if (!lk_hit) begin
                  status <= sca_pkg::STAT_NOPOOL;
                  done   <= 1'b1;
                end else begin
                  p_q      <= lk_p;
                  slot_q   <= window_index - psel.first;
                  size_q   <= psel.size;
                  widx_q   <= window_index;
                  addr_acc <= psel.second ? secondary : primary;
                  reg_acc  <= primary + {32'b0, ctrl_ofs};
                  k        <= psel.second ? {1'b0, lk_p} : '0;
                  state    <= S_QISSUE;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end

        S_ALLOC: begin
          if (adv) begin
            if (last_pool) begin
              status        <= sca_pkg::STAT_NOFIT;
              granted_index <= '1;
              done          <= 1'b1;
              state         <= S_IDLE;
            end else begin
              p_cur <= p_cur + PW'(1);
              fresh <= 1'b1;
            end
          end else if (found) begin
            slot_rows[eff_r[RW-1:0]][pick] <= 1'b1;
            granted_index <= {{(33 - IW){1'b0}}, grant_g};
            done          <= 1'b1;
            state         <= S_IDLE;
          end else begin
            r     <= eff_r + RB'(1);
            fresh <= 1'b0;
          end
        end

        S_QISSUE: begin
          if (tag_in.last) begin
            state <= S_QWAIT;
          end else begin
            k <= k + KW'(1);
          end
        end

        S_QWAIT: ;

        default: begin
          state <= S_IDLE;
        end
      endcase

      if (tag_out.valid) begin
        if (tag_out.to_reg) begin
          register_address <= reg_acc + prod64;
          window_address   <= addr_acc;
          window_size      <= {1'b0, size_q};
          status           <= sca_pkg::STAT_OK;
          granted_index    <= '0;
          done             <= 1'b1;
          state            <= S_IDLE;
        end else begin
          addr_acc <= addr_acc + prod64;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- dv/tb_size_class_window_allocator.sv -----
// Self-checking testbench for the size class window allocator: predicted replies against results.
module tb_size_class_window_allocator;

  localparam int POOLS = 4;
  localparam int SLOTS = 256;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int LAYOUT_DIRECTED = 0;
  localparam int LAYOUT_EXTREME  = 1;
  localparam int LAYOUT_EMPTY    = 2;
  localparam int LAYOUT_RANDOM   = 3;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_REQUESTS  = 210;
  localparam logic [39:0] WIDEST_SIZE = '1;
  localparam logic [40:0] SIZE_BEYOND = 41'h100_0000_0000;

  typedef struct packed {
    logic [1:0]  op;
    logic [40:0] want;
    logic [7:0]  widx;
  } alloc_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [32:0] granted;
    logic [40:0] wsize;
    logic [63:0] waddr;
    logic [63:0] raddr;
  } window_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] mode = '0;
  logic [40:0] request_size = '0;
  logic [7:0] window_index = '0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [63:0] wr_data = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic signed [32:0] granted_index;
  logic [40:0] window_size;
  logic [63:0] window_address;
  logic [63:0] register_address;

  size_class_window_allocator DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .request_size(request_size),
    .window_index(window_index),
    .done(done),
    .status(status),
    .granted_index(granted_index),
    .window_size(window_size),
    .window_address(window_address),
    .register_address(register_address),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // allocator model state
  sca_pkg::pool_t pool_reg [POOLS];
  logic [63:0] primary_base = '0;
  logic [63:0] secondary_base = '0;
  logic [31:0] ctrl_offset = '0;
  logic [15:0] ctrl_stride = '0;
  bit          slot_busy [SLOTS];
  logic [31:0] bk_count = '0;

  // layout the stimulus plans to program next
  sca_pkg::pool_t next_pool [POOLS];
  logic [63:0] next_primary, next_secondary;
  logic [31:0] next_offset;
  logic [15:0] next_stride;

  alloc_request_t request_queue [$];
  window_reply_t  awaited_replies [$];
  bit accepted = 1'b0;
  int idle_pct = 0;
  int mismatches = 0;
  int n_requests = 0, n_replies = 0, n_grants = 0, n_nofit = 0, n_nopool = 0;
  int n_bookkeeping = 0, n_layouts = 0;

  initial begin
    for (int i = 0; i < POOLS; i++) pool_reg[i] = '0;
  end

  function automatic sca_pkg::pool_t make_pool(bit second, int first, int count,
                                               logic [39:0] size);
    sca_pkg::pool_t r;
    r.second = second;
    r.first = 8'(first);
    r.count = 9'(count);
    r.size = size;
    return r;
  endfunction

  function automatic int owner_pool(logic [7:0] widx);
    int p;
    owner_pool = -1;
    for (p = POOLS - 1; p >= 0; p--)
      if (int'(widx) >= int'(pool_reg[p].first) &&
          int'(widx) < int'(pool_reg[p].first) + int'(pool_reg[p].count))
        owner_pool = p;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [63:0] d);
    case (idx)
      sca_pkg::REG_PRIMARY:     primary_base = d;
      sca_pkg::REG_SECONDARY:   secondary_base = d;
      sca_pkg::REG_CTRL_OFS:    ctrl_offset = d[31:0];
      sca_pkg::REG_CTRL_STRIDE: ctrl_stride = d[15:0];
      default: begin
        if (int'(idx - sca_pkg::REG_POOL0) < sca_pkg::NUM_POOL_REGS)
          pool_reg[2'(idx - sca_pkg::REG_POOL0)] = d[57:0];
      end
    endcase
  endfunction

  function automatic window_reply_t predict_reply(logic [1:0] op, logic [40:0] want,
                                                  logic [7:0] widx);
    window_reply_t r;
    int p, q, i, g, hit;
    bit any;
    logic [63:0] offs, slot, psize;
    r = '0;
    case (op)
      sca_pkg::MODE_ALLOC: begin
        any = 1'b0;
        for (p = 0; p < POOLS; p++) if (pool_reg[p].count != 0) any = 1'b1;
        if (!any) begin
          r.granted = {1'b0, bk_count};
          bk_count = bk_count + 32'd1;
          n_bookkeeping++;
        end else begin
          hit = -1;
          for (p = 0; p < POOLS && hit < 0; p++)
            if (want <= {1'b0, pool_reg[p].size})
              for (i = 0; i < int'(pool_reg[p].count) && hit < 0; i++) begin
                g = int'(pool_reg[p].first) + i;
                if (g < SLOTS && !slot_busy[g]) hit = g;
              end
          if (hit < 0) begin
            r.status = sca_pkg::STAT_NOFIT;
            r.granted = '1;
            n_nofit++;
          end else begin
            slot_busy[hit] = 1'b1;
            r.granted = 33'(hit);
            n_grants++;
          end
        end
      end
      sca_pkg::MODE_FREE: begin
        p = owner_pool(widx);
        if (p < 0) begin
          r.status = sca_pkg::STAT_NOPOOL;
          n_nopool++;
        end else begin
          slot_busy[widx] = 1'b0;
        end
      end
      sca_pkg::MODE_QUERY: begin
        p = owner_pool(widx);
        if (p < 0) begin
          r.status = sca_pkg::STAT_NOPOOL;
          n_nopool++;
        end else begin
          slot = 64'(widx - pool_reg[p].first);
          psize = 64'(pool_reg[p].size);
          if (pool_reg[p].second) begin
            r.waddr = secondary_base + slot * psize;
          end else begin
            offs = '0;
            for (q = 0; q < p; q++)
              if (!pool_reg[q].second)
                offs = offs + 64'(pool_reg[q].count) * 64'(pool_reg[q].size);
            r.waddr = primary_base + offs + slot * psize;
          end
          r.wsize = {1'b0, pool_reg[p].size};
          r.raddr = primary_base + 64'(ctrl_offset) + 64'(widx) * 64'(ctrl_stride);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  task automatic queue_request(input logic [1:0] op, input logic [40:0] want,
                               input logic [7:0] widx);
    alloc_request_t r;
    r.op = op;
    r.want = want;
    r.widx = widx;
    request_queue = {request_queue, r};
  endtask

  task automatic settle();
    while (request_queue.size() != 0 || start || awaited_replies.size() != 0 || busy !== 1'b0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= d;
  endtask

  task automatic reprogram(input int flavour);
    int p;
    settle();
    case (flavour)
      LAYOUT_DIRECTED: begin
        next_pool[0] = make_pool(1'b0, 0, 4, 40'h1000);
        next_pool[1] = make_pool(1'b1, 4, 8, 40'h1_0000);
        next_pool[2] = make_pool(1'b0, 250, 2, WIDEST_SIZE);
        next_pool[3] = make_pool(1'b0, 254, 511, WIDEST_SIZE);
        next_primary = 64'hFFFF_FFFF_FFFF_F000;
        next_secondary = 64'h8000_0000_0000_0000;
        next_offset = '1;
        next_stride = '1;
      end
      LAYOUT_EXTREME: begin
        next_pool[0] = make_pool(1'b1, 255, 511, WIDEST_SIZE);
        next_pool[1] = make_pool(1'b0, 0, 1, 40'd1);
        next_pool[2] = make_pool(1'b0, 0, 511, WIDEST_SIZE);
        next_pool[3] = make_pool(1'b1, 0, 0, '0);
        next_primary = '1;
        next_secondary = '1;
        next_offset = '1;
        next_stride = '1;
      end
      LAYOUT_EMPTY: begin
        for (p = 0; p < POOLS; p++)
          next_pool[p] = make_pool(1'b0, $urandom_range(0, 255), 0, 40'($urandom));
        next_primary = '0;
        next_secondary = '0;
        next_offset = '0;
        next_stride = '0;
      end
      default: begin
        for (p = 0; p < POOLS; p++) begin
          case ($urandom_range(0, 5))
            0: next_pool[p].size = '0;
            1: next_pool[p].size = WIDEST_SIZE;
            2, 3: next_pool[p].size = 40'($urandom_range(1, 255)) << $urandom_range(0, 30);
            4: next_pool[p].size = {8'($urandom), 32'($urandom)};
            default: next_pool[p].size = 40'd1 << $urandom_range(0, 39);
          endcase
          case ($urandom_range(0, 9))
            0: next_pool[p].count = '0;
            1: next_pool[p].count = 9'd511;
            default: next_pool[p].count = 9'($urandom_range(1, 48));
          endcase
          next_pool[p].first = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(200, 255))
                                                           : 8'($urandom_range(0, 255));
          next_pool[p].second = 1'($urandom_range(0, 1));
        end
        next_primary = {32'($urandom), 32'($urandom)};
        next_secondary = {32'($urandom), 32'($urandom)};
        next_offset = 32'($urandom);
        next_stride = 16'($urandom_range(0, 65535));
      end
    endcase
    for (p = 0; p < POOLS; p++)
      write_reg(sca_pkg::REG_POOL0 + 3'(p), 64'(next_pool[p]));
    write_reg(sca_pkg::REG_PRIMARY, next_primary);
    write_reg(sca_pkg::REG_SECONDARY, next_secondary);
    write_reg(sca_pkg::REG_CTRL_OFS, 64'(next_offset));
    write_reg(sca_pkg::REG_CTRL_STRIDE, 64'(next_stride));
    @(negedge clk);
    wr_en <= 1'b0;
    n_layouts++;
  endtask

  // request driver
  always @(negedge clk) begin
    alloc_request_t nxt;
    logic go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = start && !accepted;
      if (!go && request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = request_queue.pop_front();
        mode <= nxt.op;
        request_size <= nxt.want;
        window_index <= nxt.widx;
        go = 1'b1;
      end
      start <= go;
    end
  end

  // result monitor and predictor
  always @(posedge clk) begin
    window_reply_t due;
    if (rst) begin
      accepted = 1'b0;
    end else begin
      if (done) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, status %0d", $time, status);
        end else begin
          due = awaited_replies.pop_front();
          n_replies++;
          check_field("status", 64'(due.status), 64'(status));
          check_field("granted_index", 64'(due.granted), 64'($unsigned(granted_index)));
          check_field("window_size", 64'(due.wsize), 64'(window_size));
          check_field("window_address", due.waddr, window_address);
          check_field("register_address", due.raddr, register_address);
        end
      end
      if (wr_en) apply_register(wr_index, wr_data);
      accepted = start && !busy;
      if (accepted) begin
        n_requests++;
        awaited_replies = {awaited_replies, predict_reply(mode, request_size, window_index)};
      end
    end
  end

  initial begin
    int ph, n, p, roll, span;
    logic [40:0] sz, want;
    logic [7:0] widx;
    logic [1:0] op;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // all pools empty after reset: bookkeeping numbers and no-pool replies
    queue_request(sca_pkg::MODE_ALLOC, '0, '0);
    queue_request(sca_pkg::MODE_ALLOC, SIZE_BEYOND, 8'd255);
    queue_request(sca_pkg::MODE_FREE, '0, 8'd7);
    queue_request(sca_pkg::MODE_QUERY, '0, 8'd7);
    queue_request(MODE_UNUSED, '1, '1);

    reprogram(LAYOUT_DIRECTED);
    queue_request(sca_pkg::MODE_ALLOC, '0, '0);
    queue_request(sca_pkg::MODE_ALLOC, SIZE_BEYOND, '0);
    queue_request(sca_pkg::MODE_ALLOC, {1'b0, WIDEST_SIZE}, '0);
    queue_request(sca_pkg::MODE_ALLOC, 41'h1001, '0);
    queue_request(sca_pkg::MODE_QUERY, '0, 8'd0);
    queue_request(sca_pkg::MODE_QUERY, '0, 8'd7);
    queue_request(sca_pkg::MODE_QUERY, '0, 8'd251);
    queue_request(sca_pkg::MODE_QUERY, '0, 8'd255);
    queue_request(sca_pkg::MODE_QUERY, '0, 8'd252);
    queue_request(sca_pkg::MODE_FREE, '0, 8'd252);
    queue_request(sca_pkg::MODE_FREE, '0, 8'd0);
    queue_request(sca_pkg::MODE_ALLOC, '0, '0);
    queue_request(sca_pkg::MODE_FREE, '0, 8'd255);
    queue_request(MODE_UNUSED, SIZE_BEYOND, 8'd255);
    queue_request(sca_pkg::MODE_QUERY, '0, 8'd4);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: reprogram(LAYOUT_EXTREME);
        3: reprogram(LAYOUT_EMPTY);
        default: reprogram(LAYOUT_RANDOM);
      endcase
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 47;
        default: idle_pct = 27;
      endcase
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        roll = $urandom_range(0, 99);
        p = $urandom_range(0, POOLS - 1);
        sz = {1'b0, next_pool[p].size};
        span = int'(next_pool[p].count);
        if (span != 0 && $urandom_range(0, 9) < 8)
          widx = 8'(int'(next_pool[p].first) + $urandom_range(0, span - 1));
        else
          widx = 8'($urandom);
        case ($urandom_range(0, 7))
          0: want = '0;
          1: want = sz;
          2: want = sz + 1;
          3: want = (sz == 0) ? '0 : sz - 1;
          4: want = SIZE_BEYOND;
          5: want = {1'b0, 8'($urandom), 32'($urandom)};
          default: want = 41'($urandom_range(0, 4096));
        endcase
        if (roll < 48) op = sca_pkg::MODE_ALLOC;
        else if (roll < 76) op = sca_pkg::MODE_FREE;
        else if (roll < 97) op = sca_pkg::MODE_QUERY;
        else op = MODE_UNUSED;
        queue_request(op, want, widx);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("Checked %0d results for %0d requests across %0d pool layouts.",
             n_replies, n_requests, n_layouts);
    $display("Grants %0d, no fit %0d, no pool %0d, bookkeeping numbers %0d.",
             n_grants, n_nofit, n_nopool, n_bookkeeping);
    if (mismatches == 0 && awaited_replies.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d requests queued and %0d results outstanding",
             request_queue.size(), awaited_replies.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
